// File: hw/rtl/hrg_pkg.sv
// shared types and register codes for the halo range generator
`default_nettype none

package hrg_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
	localparam logic [2:0] REG_HALO_DEPTH = 3'd1;
	localparam logic [2:0] REG_SPACE_LO_X = 3'd2;
	localparam logic [2:0] REG_SPACE_HI_X = 3'd3;
	localparam logic [2:0] REG_SPACE_LO_Y = 3'd4;
	localparam logic [2:0] REG_SPACE_HI_Y = 3'd5;
	localparam logic [2:0] REG_SPACE_LO_Z = 3'd6;
	localparam logic [2:0] REG_SPACE_HI_Z = 3'd7;

	localparam int NUM_DIMS_MAX = 3;
	// box plus a below and an above slab per dimension
	localparam int SLOT_COUNT = 1 + 2 * NUM_DIMS_MAX;

	// one owned box
	typedef struct packed {
		logic [9:0]         owner_task;
		logic [15:0]        group_tag;
		logic signed [31:0] box_lo_x;
		logic signed [31:0] box_hi_x;
		logic signed [31:0] box_lo_y;
		logic signed [31:0] box_hi_y;
		logic signed [31:0] box_lo_z;
		logic signed [31:0] box_hi_z;
	} box_item_t;

	// one emitted range
	typedef struct packed {
		logic [9:0]         out_task;
		logic [15:0]        out_tag;
		logic signed [31:0] out_lo_x;
		logic signed [31:0] out_hi_x;
		logic signed [31:0] out_lo_y;
		logic signed [31:0] out_hi_y;
		logic signed [31:0] out_lo_z;
		logic signed [31:0] out_hi_z;
		logic               is_last;
	} range_item_t;

	// current configuration
	typedef struct packed {
		logic [1:0]                     num_dims;
		logic [15:0]                    halo_depth;
		logic [NUM_DIMS_MAX-1:0][31:0] space_lo;
		logic [NUM_DIMS_MAX-1:0][31:0] space_hi;
	} cfg_t;

	// box with its slab bounds and the set of ranges still to send
	typedef struct packed {
		box_item_t                      box;
		logic [NUM_DIMS_MAX-1:0][31:0] slab_lo;
		logic [NUM_DIMS_MAX-1:0][31:0] slab_hi;
		logic [SLOT_COUNT-1:0]          mask;
	} work_t;

endpackage

`default_nettype wire

// File: hw/rtl/hrg_cfg.sv
// configuration registers of the halo range generator
`default_nettype none

module hrg_cfg
	import hrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_dims   <= 2'd1;
			cfg_q.halo_depth <= 16'd1;
			cfg_q.space_lo   <= '0;
			cfg_q.space_hi   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_DIMS:   cfg_q.num_dims    <= cfg_data[1:0];
				REG_HALO_DEPTH: cfg_q.halo_depth  <= cfg_data[15:0];
				REG_SPACE_LO_X: cfg_q.space_lo[0] <= cfg_data;
				REG_SPACE_HI_X: cfg_q.space_hi[0] <= cfg_data;
				REG_SPACE_LO_Y: cfg_q.space_lo[1] <= cfg_data;
				REG_SPACE_HI_Y: cfg_q.space_hi[1] <= cfg_data;
				REG_SPACE_LO_Z: cfg_q.space_lo[2] <= cfg_data;
				REG_SPACE_HI_Z: cfg_q.space_hi[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/hrg_test.sv
// front stages: threshold sums, then bound compares and slab bounds
`default_nettype none

module hrg_test
	import hrg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      accept,
	input  wire box_item_t box,
	output logic           stall,
	input  wire logic      take,
	output logic           work_valid,
	output work_t          work
);

	// stage 1: captured box and widened thresholds
	logic                     valid_s1;
	box_item_t                box_s1;
	logic signed [33:0]       thr_lo_s1 [NUM_DIMS_MAX];
	logic signed [33:0]       thr_hi_s1 [NUM_DIMS_MAX];
	logic [NUM_DIMS_MAX-1:0]  en_s1;
	logic [15:0]              depth_s1;

	// stage 2: compare results and slab bounds
	logic  valid_s2;
	work_t work_s2;

	logic adv_s1;
	logic adv_s2;

	logic signed [33:0]      thr_lo [NUM_DIMS_MAX];
	logic signed [33:0]      thr_hi [NUM_DIMS_MAX];
	logic [NUM_DIMS_MAX-1:0] en;
	logic [31:0]             blo [NUM_DIMS_MAX];
	logic [31:0]             bhi [NUM_DIMS_MAX];
	work_t                   work_d;

	// stall control
	assign adv_s2 = !valid_s2 || take;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign stall  = valid_s1 && !adv_s2;

	// thresholds from the configuration
	always_comb begin
		for (int d = 0; d < NUM_DIMS_MAX; d++) begin
			thr_lo[d] = $signed({{2{cfg.space_lo[d][31]}}, cfg.space_lo[d]})
				+ $signed({18'd0, cfg.halo_depth});
			thr_hi[d] = $signed({{2{cfg.space_hi[d][31]}}, cfg.space_hi[d]})
				- $signed({18'd0, cfg.halo_depth});
		end
		// x always examined, zero acts as one
		en[0] = 1'b1;
		en[1] = (cfg.num_dims == 2'd2) || (cfg.num_dims == 2'd3);
		en[2] = (cfg.num_dims == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && accept) begin
			box_s1    <= box;
			thr_lo_s1 <= thr_lo;
			thr_hi_s1 <= thr_hi;
			en_s1     <= en;
			depth_s1  <= cfg.halo_depth;
		end
	end

	// compare and slab bounds
	assign blo[0] = box_s1.box_lo_x;
	assign bhi[0] = box_s1.box_hi_x;
	assign blo[1] = box_s1.box_lo_y;
	assign bhi[1] = box_s1.box_hi_y;
	assign blo[2] = box_s1.box_lo_z;
	assign bhi[2] = box_s1.box_hi_z;

	always_comb begin
		work_d.box     = box_s1;
		work_d.mask    = '0;
		work_d.mask[0] = 1'b1;
		work_d.slab_lo = '0;
		work_d.slab_hi = '0;
		for (int d = 0; d < NUM_DIMS_MAX; d++) begin
			work_d.slab_lo[d] = blo[d] - {16'd0, depth_s1};
			work_d.slab_hi[d] = bhi[d] + {16'd0, depth_s1};
			work_d.mask[1 + 2 * d] = en_s1[d]
				&& ($signed({{2{blo[d][31]}}, blo[d]}) > thr_lo_s1[d]);
			work_d.mask[2 + 2 * d] = en_s1[d]
				&& ($signed({{2{bhi[d][31]}}, bhi[d]}) < thr_hi_s1[d]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			work_s2 <= work_d;
		end
	end

	assign work_valid = valid_s2;
	assign work       = work_s2;

endmodule

`default_nettype wire

// File: hw/rtl/hrg_emit.sv
// range sequencer: sends the box and its slabs one per cycle
`default_nettype none

module hrg_emit
	import hrg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     work_valid,
	input  wire work_t    work,
	output logic          take,
	output logic          range_valid,
	output range_item_t   range_item
);

	logic                  valid_s3;
	work_t                 work_s3;
	logic [SLOT_COUNT-1:0] sel;
	logic [SLOT_COUNT-1:0] remain;
	range_item_t           next_range;
	logic                  range_valid_q;
	range_item_t           range_q;

	// pick the lowest pending range
	assign sel    = work_s3.mask & (~work_s3.mask + SLOT_COUNT'(1));
	assign remain = work_s3.mask & ~sel;
	assign take   = !valid_s3 || (remain == '0);

	// build the selected range from the box
	always_comb begin
		next_range.out_task = work_s3.box.owner_task;
		next_range.out_tag  = work_s3.box.group_tag;
		next_range.out_lo_x = work_s3.box.box_lo_x;
		next_range.out_hi_x = work_s3.box.box_hi_x;
		next_range.out_lo_y = work_s3.box.box_lo_y;
		next_range.out_hi_y = work_s3.box.box_hi_y;
		next_range.out_lo_z = work_s3.box.box_lo_z;
		next_range.out_hi_z = work_s3.box.box_hi_z;
		next_range.is_last  = (remain == '0);
		if (sel[1]) begin
			next_range.out_lo_x = work_s3.slab_lo[0];
			next_range.out_hi_x = work_s3.box.box_lo_x;
		end
		if (sel[2]) begin
			next_range.out_lo_x = work_s3.box.box_hi_x;
			next_range.out_hi_x = work_s3.slab_hi[0];
		end
		if (sel[3]) begin
			next_range.out_lo_y = work_s3.slab_lo[1];
			next_range.out_hi_y = work_s3.box.box_lo_y;
		end
		if (sel[4]) begin
			next_range.out_lo_y = work_s3.box.box_hi_y;
			next_range.out_hi_y = work_s3.slab_hi[1];
		end
		if (sel[5]) begin
			next_range.out_lo_z = work_s3.slab_lo[2];
			next_range.out_hi_z = work_s3.box.box_lo_z;
		end
		if (sel[6]) begin
			next_range.out_lo_z = work_s3.box.box_hi_z;
			next_range.out_hi_z = work_s3.slab_hi[2];
		end
	end

	// sequencer stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take) begin
			valid_s3 <= work_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (work_valid) begin
				work_s3 <= work;
			end
		end else begin
			work_s3.mask <= remain;
		end
	end

	// output register, one transfer per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_valid_q <= 1'b0;
		end else begin
			range_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			range_q <= next_range;
		end
	end

	assign range_valid = range_valid_q;
	assign range_item  = range_q;

endmodule

`default_nettype wire

// File: hw/rtl/halo_range_generator.sv
// top level of the halo range generator
`default_nettype none

// Takes one owned box per transfer on start/box while busy is low and sends
// the box itself followed by its halo slabs (below x, above x, below y, above
// y, below z, above z), each slab only when its dimension is examined and it
// lies inside the space bounds. Each range is on range_item for exactly one
// cycle, marked by range_valid; the last range of a box has is_last set. The
// receiver cannot stall. Configuration goes through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. A box passes stage 1, stage 2, the sequencer stage and the
// output register before its first range is on the ports; the others follow
// back to back. A box with k ranges (1 to 7) holds the range sequencer until
// its last range is sent, so boxes with no slabs go in every cycle; busy rises
// while the sequencer is still sending an earlier box and the front stages are
// full. Reset clears all valid bits and sets num_dims = 1, halo_depth = 1 and
// all space bounds to zero.
module halo_range_generator
	import hrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire box_item_t   box,
	output logic             range_valid,
	output range_item_t      range_item,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t  cfg;
	logic  accept;
	logic  stall;
	logic  take;
	logic  work_valid;
	work_t work;

	// input transfer
	assign busy   = stall;
	assign accept = start && !stall;

	hrg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hrg_test u_test (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.box        (box),
		.stall      (stall),
		.take       (take),
		.work_valid (work_valid),
		.work       (work)
	);

	hrg_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.work_valid  (work_valid),
		.work        (work),
		.take        (take),
		.range_valid (range_valid),
		.range_item  (range_item)
	);

endmodule

`default_nettype wire

// File: tb/hrg_range_checker.sv
// watches the box and range channels of the halo range generator and checks every range
`default_nettype none

module hrg_range_checker
	import hrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire box_item_t   box,
	input  wire logic        range_valid,
	input  wire range_item_t range_item,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               errors,
	output int               ranges_due
);

	localparam int MAX_REPORTS = 10;

	// shadow copy of the configuration registers
	logic [1:0]       num_dims_q;
	logic [15:0]      depth_q;
	logic [2:0][31:0] space_lo_q;
	logic [2:0][31:0] space_hi_q;

	// ranges still to come, oldest first
	range_item_t awaited_ranges[$];

	function automatic string fmt_range(input range_item_t r);
		return $sformatf("task=%0d tag=%0d x=[%0d,%0d) y=[%0d,%0d) z=[%0d,%0d) last=%0b",
			r.out_task, r.out_tag, r.out_lo_x, r.out_hi_x, r.out_lo_y, r.out_hi_y,
			r.out_lo_z, r.out_hi_z, r.is_last);
	endfunction

	function automatic range_item_t make_range(input box_item_t b,
			input logic [2:0][31:0] lo, input logic [2:0][31:0] hi);
		range_item_t r;
		r.out_task = b.owner_task;
		r.out_tag  = b.group_tag;
		r.out_lo_x = lo[0];
		r.out_hi_x = hi[0];
		r.out_lo_y = lo[1];
		r.out_hi_y = hi[1];
		r.out_lo_z = lo[2];
		r.out_hi_z = hi[2];
		r.is_last  = 1'b0;
		return r;
	endfunction

	// the box itself, then below/above slabs per examined dimension
	function automatic void predict_ranges(input box_item_t b);
		range_item_t      found[SLOT_COUNT];
		logic [2:0][31:0] blo;
		logic [2:0][31:0] bhi;
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
		longint           dep;
		longint           bl;
		longint           bh;
		longint           sl;
		longint           sh;
		int               dims;
		int               n;
		blo  = {b.box_lo_z, b.box_lo_y, b.box_lo_x};
		bhi  = {b.box_hi_z, b.box_hi_y, b.box_hi_x};
		dep  = longint'(depth_q);
		dims = (num_dims_q == 2'd0) ? 1 : int'(num_dims_q);
		n    = 0;
		found[n] = make_range(b, blo, bhi);
		n++;
		for (int d = 0; d < dims; d++) begin
			bl = longint'($signed(blo[d]));
			bh = longint'($signed(bhi[d]));
			sl = longint'($signed(space_lo_q[d]));
			sh = longint'($signed(space_hi_q[d]));
			if (bl > sl + dep) begin
				lo    = blo;
				hi    = bhi;
				hi[d] = blo[d];
				lo[d] = 32'(bl - dep);
				found[n] = make_range(b, lo, hi);
				n++;
			end
			if (bh < sh - dep) begin
				lo    = blo;
				hi    = bhi;
				lo[d] = bhi[d];
				hi[d] = 32'(bh + dep);
				found[n] = make_range(b, lo, hi);
				n++;
			end
		end
		found[n-1].is_last = 1'b1;
		for (int k = 0; k < n; k++)
			awaited_ranges.push_back(found[k]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		range_item_t want;
		if (!arst_n) begin
			num_dims_q = 2'd1;
			depth_q    = 16'd1;
			space_lo_q = '0;
			space_hi_q = '0;
			awaited_ranges.delete();
			errors     = 0;
			ranges_due <= 0;
		end else begin
			// result transfer: compare with the oldest awaited range
			if (range_valid) begin
				if (awaited_ranges.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected range at %0t: %s", $time, fmt_range(range_item));
				end else begin
					want = awaited_ranges.pop_front();
					if (range_item !== want) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("range mismatch at %0t, expected: %s", $time, fmt_range(want));
							$display("range mismatch at %0t, actual:   %s", $time,
								fmt_range(range_item));
						end
					end
				end
			end
			// box transfer
			if (start && !busy)
				predict_ranges(box);
			// register write takes effect after this edge
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_DIMS:   num_dims_q = cfg_data[1:0];
					REG_HALO_DEPTH: depth_q = cfg_data[15:0];
					REG_SPACE_LO_X: space_lo_q[0] = cfg_data;
					REG_SPACE_HI_X: space_hi_q[0] = cfg_data;
					REG_SPACE_LO_Y: space_lo_q[1] = cfg_data;
					REG_SPACE_HI_Y: space_hi_q[1] = cfg_data;
					REG_SPACE_LO_Z: space_lo_q[2] = cfg_data;
					REG_SPACE_HI_Z: space_hi_q[2] = cfg_data;
					default: ;
				endcase
			end
			ranges_due <= awaited_ranges.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_halo_range_generator.sv
// testbench top for the halo range generator: clock, reset, stimulus and verdict
`default_nettype none

module tb_halo_range_generator;
	import hrg_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;
	localparam int RANDOM_PHASES = 6;
	localparam int BOXES_PER_PHASE = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	box_item_t   box = '0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_NUM_DIMS;
	logic [31:0] cfg_data = '0;
	logic        busy;
	logic        range_valid;
	range_item_t range_item;
	int          errors;
	int          ranges_due;
	int          cycles = 0;

	// configuration as last written, used to shape random boxes
	longint cur_dep;
	longint cur_lo[3];
	longint cur_hi[3];

	halo_range_generator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.box        (box),
		.range_valid(range_valid),
		.range_item (range_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	hrg_range_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.box        (box),
		.range_valid(range_valid),
		.range_item (range_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.ranges_due (ranges_due)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic box_item_t mk_box(input logic [9:0] t, input logic [15:0] g,
			input logic [31:0] lx, input logic [31:0] hx, input logic [31:0] ly,
			input logic [31:0] hy, input logic [31:0] lz, input logic [31:0] hz);
		box_item_t b;
		b.owner_task = t;
		b.group_tag  = g;
		b.box_lo_x   = lx;
		b.box_hi_x   = hx;
		b.box_lo_y   = ly;
		b.box_hi_y   = hy;
		b.box_lo_z   = lz;
		b.box_hi_z   = hz;
		return b;
	endfunction

	// shaped boxes sit near the slab thresholds, the rest is raw noise
	function automatic box_item_t random_box(input bit shaped);
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
		int               off;
		for (int d = 0; d < 3; d++) begin
			if (shaped) begin
				off = $urandom_range(0, 1) ? $urandom_range(0, 5) - 2 : $urandom_range(0, 1000);
				lo[d] = 32'(cur_lo[d] + cur_dep + off);
				off = $urandom_range(0, 1) ? $urandom_range(0, 5) - 2 : $urandom_range(0, 1000);
				hi[d] = 32'(cur_hi[d] - cur_dep - off);
			end else begin
				lo[d] = $urandom;
				hi[d] = $urandom;
			end
		end
		return mk_box(10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
			lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
	endfunction

	// drop start and wait until every awaited range has come out
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (ranges_due != 0);
	endtask

	// one box transfer after an optional gap; start stays high for a follow-on box
	task automatic send_box(input box_item_t b, input bit burst);
		int gap;
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		box   <= b;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] nd, input logic [15:0] dep,
			input logic [2:0][31:0] lo, input logic [2:0][31:0] hi);
		wait_idle();
		write_reg(REG_NUM_DIMS, {30'd0, nd});
		write_reg(REG_HALO_DEPTH, {16'd0, dep});
		write_reg(REG_SPACE_LO_X, lo[0]);
		write_reg(REG_SPACE_HI_X, hi[0]);
		write_reg(REG_SPACE_LO_Y, lo[1]);
		write_reg(REG_SPACE_HI_Y, hi[1]);
		write_reg(REG_SPACE_LO_Z, lo[2]);
		write_reg(REG_SPACE_HI_Z, hi[2]);
		cfg_we <= 1'b0;
		cur_dep = longint'(dep);
		for (int d = 0; d < 3; d++) begin
			cur_lo[d] = longint'($signed(lo[d]));
			cur_hi[d] = longint'($signed(hi[d]));
		end
	endtask

	task automatic random_config();
		logic [1:0]       nd;
		logic [15:0]      dep;
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
		int               base;
		nd = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0:       dep = 16'd0;
			1:       dep = 16'($urandom_range(1, 8));
			2:       dep = 16'($urandom);
			default: dep = 16'hFFFF;
		endcase
		for (int d = 0; d < 3; d++) begin
			case ($urandom_range(0, 3))
				0: begin
					lo[d] = 32'h8000_0000;
					hi[d] = 32'h7FFF_FFFF;
				end
				1, 2: begin
					base  = $urandom_range(0, 4000);
					base  = base - 2000;
					lo[d] = base;
					hi[d] = base + 2 * int'(dep) + $urandom_range(0, 3000);
				end
				default: begin
					lo[d] = $urandom;
					hi[d] = $urandom;
				end
			endcase
		end
		set_config(nd, dep, lo, hi);
	endtask

	initial begin
		bit burst;
		cur_dep = 1;
		for (int d = 0; d < 3; d++) begin
			cur_lo[d] = 0;
			cur_hi[d] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: one dimension, depth one, empty space at zero
		send_box(mk_box(10'd0, 16'd1, 32'd5, 32'd10, 32'd0, 32'd0, 32'd0, 32'd0), 1'b0);
		send_box(mk_box(10'd1023, 16'hFFFF, -32'sd5, -32'sd2, 32'd7, 32'd9,
			32'h8000_0000, 32'h7FFF_FFFF), 1'b0);
		// tag zero and an empty box
		send_box(mk_box(10'h155, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0), 1'b0);
		// inverted box at the extremes
		send_box(mk_box(10'h2AA, 16'hAAAA, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'd0), 1'b0);

		// three dimensions: all six slabs, and boxes right at the thresholds
		set_config(2'd3, 16'd2, {-32'sd100, -32'sd100, -32'sd100},
			{32'sd100, 32'sd100, 32'sd100});
		send_box(mk_box(10'd3, 16'd7, -32'sd50, 32'sd50, -32'sd50, 32'sd50,
			-32'sd50, 32'sd50), 1'b0);
		send_box(mk_box(10'd4, 16'd8, -32'sd98, 32'sd98, -32'sd97, 32'sd97,
			-32'sd98, 32'sd97), 1'b1);
		send_box(mk_box(10'd512, 16'h8000, -32'sd200, 32'sd200, 32'sd0, 32'sd1,
			-32'sd99, -32'sd99), 1'b1);

		// dimension count zero acts as one; depth zero gives empty slabs
		set_config(2'd0, 16'd0, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		send_box(mk_box(10'd5, 16'd9, 32'h8000_0001, 32'h7FFF_FFFE, 32'h8000_0001,
			32'h7FFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFE), 1'b0);
		send_box(mk_box(10'd6, 16'd10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0);

		// widest depth with full-range x space, z left unexamined
		set_config(2'd2, 16'hFFFF, {32'hDEAD_BEEF, 32'd0, 32'h8000_0000},
			{32'h1234_5678, 32'h0002_0000, 32'h7FFF_FFFF});
		send_box(mk_box(10'd7, 16'd11, 32'd0, 32'd100, 32'd70000, 32'd70001,
			32'd5, 32'd6), 1'b0);
		send_box(mk_box(10'd8, 16'd12, 32'h8000_FFFF, 32'h7FFF_0000, 32'd65535,
			32'd65536, 32'h8000_0000, 32'h7FFF_FFFF), 1'b0);
		send_box(mk_box(10'd9, 16'd13, 32'h8001_0000, 32'h7FFE_FFFF, 32'd65536,
			32'd65535, 32'd0, 32'd0), 1'b0);

		// inverted space bounds
		set_config(2'd3, 16'd1, {32'sd100, 32'sd100, 32'sd100},
			{-32'sd100, -32'sd100, -32'sd100});
		send_box(mk_box(10'd1, 16'd2, 32'sd200, -32'sd200, 32'sd101, -32'sd101,
			32'sd102, -32'sd102), 1'b0);

		// random phases, each under a fresh configuration
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_config();
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < BOXES_PER_PHASE; i++)
				send_box(random_box($urandom_range(0, 3) != 0), burst);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/hrg_pkg.sv
hw/rtl/hrg_cfg.sv
hw/rtl/hrg_test.sv
hw/rtl/hrg_emit.sv
hw/rtl/halo_range_generator.sv
tb/hrg_range_checker.sv
tb/tb_halo_range_generator.sv
